FILE: src/gspd_pkg.sv
// shared types and constants for the gain scheduled pd steering block
package gspd_pkg;

   localparam int GAIN_BITS  = 12;
   localparam int SPEED_BITS = 7;
   localparam int CORR_BITS  = 8;
   localparam int HOLD_BITS  = 8;
   localparam int CSR_BITS   = 12;

   // wheel speeds and correction are limited to two decimal digits
   localparam logic [SPEED_BITS-1:0] SPEED_MAX = 7'd99;

   typedef enum logic [2:0] {
      CSR_NORMAL_KP    = 3'd0,
      CSR_NORMAL_KD    = 3'd1,
      CSR_TURN_KP      = 3'd2,
      CSR_TURN_KD      = 3'd3,
      CSR_NORMAL_SPEED = 3'd4,
      CSR_TURN_SPEED   = 3'd5,
      CSR_MAX_CORR     = 3'd6,
      CSR_HOLD_TICKS   = 3'd7
   } csr_index_type;

   localparam logic [GAIN_BITS-1:0]  RST_NORMAL_KP    = 12'd31;
   localparam logic [GAIN_BITS-1:0]  RST_NORMAL_KD    = 12'd1024;
   localparam logic [GAIN_BITS-1:0]  RST_TURN_KP      = 12'd115;
   localparam logic [GAIN_BITS-1:0]  RST_TURN_KD      = 12'd0;
   localparam logic [SPEED_BITS-1:0] RST_NORMAL_SPEED = 7'd20;
   localparam logic [SPEED_BITS-1:0] RST_TURN_SPEED   = 7'd35;
   localparam logic [SPEED_BITS-1:0] RST_MAX_CORR     = 7'd40;
   localparam logic [HOLD_BITS-1:0]  RST_HOLD_TICKS   = 8'd60;

endpackage

FILE: src/gain_scheduled_pd_steering.sv
// gain scheduled pd steering controller for a differential drive car
// path: an accepted beat moves through the stage 1, 2 and 3 registers into the rsp registers
// throughput: one beat per cycle while rsp_ready stays high, set by the four stage pipeline
//   (input capture, gain multipliers, sum and magnitude, clamp and wheel speeds)
// stalls back up stage by stage, so bubbles are squeezed out under backpressure
// reset: synchronous, active high; clears tick state, valids and reloads the default configuration
module gain_scheduled_pd_steering #(
   parameter int ERROR_BITS     = 11,
   parameter int GAIN_FRAC_BITS = 8
) (
   input  logic                                clock,
   input  logic                                reset,
   // input ticks
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic signed [ERROR_BITS-1:0]        req_position_err,
   input  logic                                req_turn_finished,
   input  logic                                req_halted,
   // results
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [gspd_pkg::SPEED_BITS-1:0]     rsp_left_speed,
   output logic [gspd_pkg::SPEED_BITS-1:0]     rsp_right_speed,
   output logic signed [gspd_pkg::CORR_BITS-1:0] rsp_correction,
   output logic                                rsp_send_enable,
   output logic                                rsp_turn_mode,
   // configuration writes
   input  logic                                csr_we,
   input  gspd_pkg::csr_index_type             csr_index,
   input  logic [gspd_pkg::CSR_BITS-1:0]       csr_wdata
);
   import gspd_pkg::*;

   // proportional product, derivative product and their sum, with headroom
   localparam int PKP_BITS = ERROR_BITS + GAIN_BITS + 1;
   localparam int PKD_BITS = ERROR_BITS + GAIN_BITS + 2;
   localparam int SUM_BITS = ERROR_BITS + GAIN_BITS + 3;

   // configuration registers
   logic [GAIN_BITS-1:0]  normal_kp_ff, normal_kd_ff, turn_kp_ff, turn_kd_ff;
   logic [SPEED_BITS-1:0] normal_speed_ff, turn_speed_ff, max_corr_ff;
   logic [HOLD_BITS-1:0]  hold_ticks_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         normal_kp_ff    <= RST_NORMAL_KP;
         normal_kd_ff    <= RST_NORMAL_KD;
         turn_kp_ff      <= RST_TURN_KP;
         turn_kd_ff      <= RST_TURN_KD;
         normal_speed_ff <= RST_NORMAL_SPEED;
         turn_speed_ff   <= RST_TURN_SPEED;
         max_corr_ff     <= RST_MAX_CORR;
         hold_ticks_ff   <= RST_HOLD_TICKS;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_NORMAL_KP:    normal_kp_ff    <= csr_wdata;
            CSR_NORMAL_KD:    normal_kd_ff    <= csr_wdata;
            CSR_TURN_KP:      turn_kp_ff      <= csr_wdata;
            CSR_TURN_KD:      turn_kd_ff      <= csr_wdata;
            CSR_NORMAL_SPEED: normal_speed_ff <= csr_wdata[SPEED_BITS-1:0];
            CSR_TURN_SPEED:   turn_speed_ff   <= csr_wdata[SPEED_BITS-1:0];
            CSR_MAX_CORR:     max_corr_ff     <= csr_wdata[SPEED_BITS-1:0];
            CSR_HOLD_TICKS:   hold_ticks_ff   <= csr_wdata[HOLD_BITS-1:0];
         endcase
      end
   end

   // stage enables: each stage moves when the one after it can take a beat
   logic s1_valid_ff, s2_valid_ff, s3_valid_ff, rsp_valid_ff;
   logic out_en, s3_en, s2_en, s1_en;

   assign out_en    = !rsp_valid_ff || rsp_ready;
   assign s3_en     = !s3_valid_ff || out_en;
   assign s2_en     = !s2_valid_ff || s3_en;
   assign s1_en     = !s1_valid_ff || s2_en;
   assign req_ready = s1_en;

   logic req_take;
   assign req_take = req_valid && req_ready;

   // tick state: last error and post-turn hold counter, updated per accepted beat
   logic signed [ERROR_BITS-1:0] prev_err_ff;
   logic                         post_turn_ff, post_turn_in;
   logic [HOLD_BITS-1:0]         hold_cnt_ff, hold_cnt_in;
   logic                         active;
   logic [HOLD_BITS-1:0]         hold_cnt_inc;

   always_comb begin
      active       = post_turn_ff || req_turn_finished;
      hold_cnt_inc = hold_cnt_ff + HOLD_BITS'(1);
      post_turn_in = post_turn_ff;
      hold_cnt_in  = hold_cnt_ff;
      if (active) begin
         // a repeated event does not restart the count; the wrap gives 256 ticks
         if (hold_cnt_inc == hold_ticks_ff) begin
            hold_cnt_in  = '0;
            post_turn_in = 1'b0;
         end else begin
            hold_cnt_in  = hold_cnt_inc;
            post_turn_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_err_ff  <= '0;
         post_turn_ff <= 1'b0;
         hold_cnt_ff  <= '0;
      end else if (req_take) begin
         prev_err_ff  <= req_position_err;
         post_turn_ff <= post_turn_in;
         hold_cnt_ff  <= hold_cnt_in;
      end
   end

   // stage 1: error, error difference and the selected gain set
   logic signed [ERROR_BITS-1:0] s1_err_ff;
   logic signed [ERROR_BITS:0]   s1_diff_ff;
   logic [GAIN_BITS-1:0]         s1_kp_ff, s1_kd_ff;
   logic [SPEED_BITS-1:0]        s1_base_ff;
   logic                         s1_turn_ff, s1_halted_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (s1_en) begin
         s1_valid_ff <= req_take;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_err_ff    <= req_position_err;
         s1_diff_ff   <= (ERROR_BITS+1)'(req_position_err) - (ERROR_BITS+1)'(prev_err_ff);
         s1_kp_ff     <= active ? turn_kp_ff : normal_kp_ff;
         s1_kd_ff     <= active ? turn_kd_ff : normal_kd_ff;
         s1_base_ff   <= active ? turn_speed_ff : normal_speed_ff;
         s1_turn_ff   <= active;
         s1_halted_ff <= req_halted;
      end
   end

   // stage 2: the two gain products
   logic signed [PKP_BITS-1:0] s2_pkp_ff, s2_pkp_in;
   logic signed [PKD_BITS-1:0] s2_pkd_ff, s2_pkd_in;
   logic [SPEED_BITS-1:0]      s2_base_ff;
   logic                       s2_turn_ff, s2_halted_ff;

   assign s2_pkp_in = PKP_BITS'($signed({1'b0, s1_kp_ff})) * PKP_BITS'(s1_err_ff);
   assign s2_pkd_in = PKD_BITS'($signed({1'b0, s1_kd_ff})) * PKD_BITS'(s1_diff_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (s2_en) begin
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s2_en && s1_valid_ff) begin
         s2_pkp_ff    <= s2_pkp_in;
         s2_pkd_ff    <= s2_pkd_in;
         s2_base_ff   <= s1_base_ff;
         s2_turn_ff   <= s1_turn_ff;
         s2_halted_ff <= s1_halted_ff;
      end
   end

   // stage 3: sum, then sign and magnitude with the fraction dropped,
   // which truncates toward zero
   logic signed [SUM_BITS-1:0] sum;
   logic [SUM_BITS-1:0]        sum_abs;
   logic [SUM_BITS-1:0]        s3_mag_ff;
   logic                       s3_neg_ff;
   logic [SPEED_BITS-1:0]      s3_base_ff;
   logic                       s3_turn_ff, s3_halted_ff;

   always_comb begin
      sum     = SUM_BITS'(s2_pkp_ff) + SUM_BITS'(s2_pkd_ff);
      sum_abs = sum[SUM_BITS-1] ? SUM_BITS'(-sum) : SUM_BITS'(sum);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end else if (s3_en) begin
         s3_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s3_en && s2_valid_ff) begin
         s3_mag_ff    <= sum_abs >> GAIN_FRAC_BITS;
         s3_neg_ff    <= sum[SUM_BITS-1];
         s3_base_ff   <= s2_base_ff;
         s3_turn_ff   <= s2_turn_ff;
         s3_halted_ff <= s2_halted_ff;
      end
   end

   // stage 4: clamp, halve toward zero and form the wheel speeds
   logic [SPEED_BITS-1:0]        lim, cmag;
   logic signed [SPEED_BITS+1:0] base_w, half_w, left_w, right_w;
   logic [SPEED_BITS-1:0]        left_in, right_in;
   logic signed [CORR_BITS-1:0]  corr_in;

   always_comb begin
      // a clamp limit above the two digit range acts as the range top
      lim    = (max_corr_ff > SPEED_MAX) ? SPEED_MAX : max_corr_ff;
      cmag   = (s3_mag_ff > SUM_BITS'(lim)) ? lim : s3_mag_ff[SPEED_BITS-1:0];
      corr_in = s3_neg_ff ? -$signed({1'b0, cmag}) : $signed({1'b0, cmag});
      base_w = $signed({2'b00, s3_base_ff});
      half_w = $signed({3'b000, cmag[SPEED_BITS-1:1]});
      left_w  = s3_neg_ff ? base_w + half_w : base_w - half_w;
      right_w = s3_neg_ff ? base_w - half_w : base_w + half_w;
      if (left_w < 0)
         left_in = '0;
      else if (left_w > $signed({2'b00, SPEED_MAX}))
         left_in = SPEED_MAX;
      else
         left_in = left_w[SPEED_BITS-1:0];
      if (right_w < 0)
         right_in = '0;
      else if (right_w > $signed({2'b00, SPEED_MAX}))
         right_in = SPEED_MAX;
      else
         right_in = right_w[SPEED_BITS-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_en) begin
         rsp_valid_ff <= s3_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (out_en && s3_valid_ff) begin
         rsp_left_speed  <= left_in;
         rsp_right_speed <= right_in;
         rsp_correction  <= corr_in;
         // a halted tick is still computed, only the send is held back
         rsp_send_enable <= !s3_halted_ff;
         rsp_turn_mode   <= s3_turn_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   // outside post-turn mode the hold counter sits at zero
   a_idle_counter : assert property (@(posedge clock) disable iff (reset)
      !post_turn_ff |-> hold_cnt_ff == '0)
      else $error("hold counter not cleared outside post-turn mode");

   // a beat held in stage 1 that cannot move on is not dropped
   a_s1_hold : assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && !s2_en |=> s1_valid_ff)
      else $error("stage 1 beat lost under stall");

   // a beat held in stage 3 that cannot move on is not dropped
   a_s3_hold : assert property (@(posedge clock) disable iff (reset)
      s3_valid_ff && !out_en |=> s3_valid_ff)
      else $error("stage 3 beat lost under stall");

   // results stay in their two digit ranges
   a_rsp_range : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_left_speed <= SPEED_MAX && rsp_right_speed <= SPEED_MAX
                    && rsp_correction <= 8'sd99 && rsp_correction >= -8'sd99)
      else $error("result out of range");

endmodule

FILE: bench/steering_checker.sv
// checker for the pd steering block: predicts each wheel command and compares result beats
`timescale 1ns / 1ps

module steering_checker #(
   parameter int ERROR_BITS     = 11,
   parameter int GAIN_FRAC_BITS = 8
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    req_valid,
   input  logic                                    req_ready,
   input  logic signed [ERROR_BITS-1:0]            req_position_err,
   input  logic                                    req_turn_finished,
   input  logic                                    req_halted,
   input  logic                                    rsp_valid,
   input  logic                                    rsp_ready,
   input  logic [gspd_pkg::SPEED_BITS-1:0]         rsp_left_speed,
   input  logic [gspd_pkg::SPEED_BITS-1:0]         rsp_right_speed,
   input  logic signed [gspd_pkg::CORR_BITS-1:0]   rsp_correction,
   input  logic                                    rsp_send_enable,
   input  logic                                    rsp_turn_mode,
   input  logic                                    csr_we,
   input  gspd_pkg::csr_index_type                 csr_index,
   input  logic [gspd_pkg::CSR_BITS-1:0]           csr_wdata,
   output int                                      fail_count,
   output int                                      cmds_in_flight
);
   import gspd_pkg::*;

   typedef struct packed {
      logic [SPEED_BITS-1:0]        left_speed;
      logic [SPEED_BITS-1:0]        right_speed;
      logic signed [CORR_BITS-1:0]  correction;
      logic                         send_enable;
      logic                         turn_mode;
   } wheel_cmd_type;

   // register copies
   logic [GAIN_BITS-1:0]         kp_normal, kd_normal, kp_turn, kd_turn;
   logic [SPEED_BITS-1:0]        base_normal, base_turn, corr_limit;
   logic [HOLD_BITS-1:0]         hold_len;

   // tick state
   logic signed [ERROR_BITS-1:0] last_err;
   logic                         turn_pending;
   logic [HOLD_BITS-1:0]         turn_ticks;

   wheel_cmd_type                pending_cmds[$];

   function automatic logic [SPEED_BITS-1:0] clamp_speed(input longint v);
      if (v < 0)
         return '0;
      if (v > longint'(SPEED_MAX))
         return SPEED_MAX;
      return v[SPEED_BITS-1:0];
   endfunction

   function automatic wheel_cmd_type predict_wheel_cmd(
                                                    input logic signed [ERROR_BITS-1:0] err,
                                                    input logic turn_evt,
                                                    input logic halt);
      longint        kp, kd, base, sum, corr, lim, half;
      logic          active;
      wheel_cmd_type cmd;
      active = turn_pending | turn_evt;
      if (active) begin
         // 8 bit count wraps, so a hold length of zero means 256 ticks
         turn_ticks = turn_ticks + HOLD_BITS'(1);
         if (turn_ticks == hold_len) begin
            turn_ticks   = '0;
            turn_pending = 1'b0;
         end else begin
            turn_pending = 1'b1;
         end
         kp   = kp_turn;
         kd   = kd_turn;
         base = base_turn;
      end else begin
         kp   = kp_normal;
         kd   = kd_normal;
         base = base_normal;
      end
      sum      = kp * longint'(err) + kd * (longint'(err) - longint'(last_err));
      last_err = err;
      // integer division truncates toward zero
      corr = sum / (longint'(1) << GAIN_FRAC_BITS);
      lim  = (corr_limit > SPEED_MAX) ? longint'(SPEED_MAX) : longint'(corr_limit);
      if (corr > lim)
         corr = lim;
      else if (corr < -lim)
         corr = -lim;
      half = corr / 2;
      cmd.left_speed  = clamp_speed(base - half);
      cmd.right_speed = clamp_speed(base + half);
      cmd.correction  = corr[CORR_BITS-1:0];
      cmd.send_enable = ~halt;
      cmd.turn_mode   = active;
      return cmd;
   endfunction

   task automatic compare_field(input string name, input logic signed [63:0] want,
                                input logic signed [63:0] got);
      if (got !== want) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         fail_count++;
      end
   endtask

   always @(posedge clock) begin
      wheel_cmd_type want;
      if (reset) begin
         kp_normal    = RST_NORMAL_KP;
         kd_normal    = RST_NORMAL_KD;
         kp_turn      = RST_TURN_KP;
         kd_turn      = RST_TURN_KD;
         base_normal  = RST_NORMAL_SPEED;
         base_turn    = RST_TURN_SPEED;
         corr_limit   = RST_MAX_CORR;
         hold_len     = RST_HOLD_TICKS;
         last_err     = '0;
         turn_pending = 1'b0;
         turn_ticks   = '0;
         pending_cmds.delete();
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_NORMAL_KP:    kp_normal   = csr_wdata[GAIN_BITS-1:0];
               CSR_NORMAL_KD:    kd_normal   = csr_wdata[GAIN_BITS-1:0];
               CSR_TURN_KP:      kp_turn     = csr_wdata[GAIN_BITS-1:0];
               CSR_TURN_KD:      kd_turn     = csr_wdata[GAIN_BITS-1:0];
               CSR_NORMAL_SPEED: base_normal = csr_wdata[SPEED_BITS-1:0];
               CSR_TURN_SPEED:   base_turn   = csr_wdata[SPEED_BITS-1:0];
               CSR_MAX_CORR:     corr_limit  = csr_wdata[SPEED_BITS-1:0];
               CSR_HOLD_TICKS:   hold_len    = csr_wdata[HOLD_BITS-1:0];
               default: ;
            endcase
         end
         if (req_valid && req_ready)
            pending_cmds.push_back(predict_wheel_cmd(req_position_err, req_turn_finished,
                                                     req_halted));
         if (rsp_valid && rsp_ready) begin
            if (pending_cmds.size() == 0) begin
               $error("result beat with no tick waiting for it");
               fail_count++;
            end else begin
               want = pending_cmds.pop_front();
               compare_field("left_speed", 64'(want.left_speed), 64'(rsp_left_speed));
               compare_field("right_speed", 64'(want.right_speed), 64'(rsp_right_speed));
               compare_field("correction", 64'($signed(want.correction)),
                             64'(rsp_correction));
               compare_field("send_enable", 64'(want.send_enable), 64'(rsp_send_enable));
               compare_field("turn_mode", 64'(want.turn_mode), 64'(rsp_turn_mode));
            end
         end
      end
      cmds_in_flight = pending_cmds.size();
   end

endmodule

FILE: bench/tb.sv
// testbench top for the pd steering block: clock, reset, tick and register stimulus, verdict
`timescale 1ns / 1ps

module tb;
   import gspd_pkg::*;

   localparam int ERR_W     = 11;
   localparam int GAIN_FRAC = 8;
   localparam int ERR_MAX   = (1 << (ERR_W - 1)) - 1;
   localparam int ERR_MIN   = -ERR_MAX - 1;

   // kinds of register setting used between phases
   typedef enum int {
      SET_LOWEST,
      SET_HIGHEST,
      SET_RANDOM,
      SET_WRAPPED_HOLD
   } setting_kind_type;

   logic                            clock;
   logic                            reset;
   logic                            req_valid;
   logic                            req_ready;
   logic signed [ERR_W-1:0]         req_position_err;
   logic                            req_turn_finished;
   logic                            req_halted;
   logic                            rsp_valid;
   logic                            rsp_ready;
   logic [SPEED_BITS-1:0]           rsp_left_speed;
   logic [SPEED_BITS-1:0]           rsp_right_speed;
   logic signed [CORR_BITS-1:0]     rsp_correction;
   logic                            rsp_send_enable;
   logic                            rsp_turn_mode;
   logic                            csr_we;
   csr_index_type                   csr_index;
   logic [CSR_BITS-1:0]             csr_wdata;

   int                              fail_count;
   int                              cmds_in_flight;
   int                              ticks_sent;
   int                              cmds_taken;
   int                              last_err_sent;

   gain_scheduled_pd_steering #(
      .ERROR_BITS     (ERR_W),
      .GAIN_FRAC_BITS (GAIN_FRAC)
   ) uut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_position_err  (req_position_err),
      .req_turn_finished (req_turn_finished),
      .req_halted        (req_halted),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_left_speed    (rsp_left_speed),
      .rsp_right_speed   (rsp_right_speed),
      .rsp_correction    (rsp_correction),
      .rsp_send_enable   (rsp_send_enable),
      .rsp_turn_mode     (rsp_turn_mode),
      .csr_we            (csr_we),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata)
   );

   steering_checker #(
      .ERROR_BITS     (ERR_W),
      .GAIN_FRAC_BITS (GAIN_FRAC)
   ) checker_i (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_position_err  (req_position_err),
      .req_turn_finished (req_turn_finished),
      .req_halted        (req_halted),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_left_speed    (rsp_left_speed),
      .rsp_right_speed   (rsp_right_speed),
      .rsp_correction    (rsp_correction),
      .rsp_send_enable   (rsp_send_enable),
      .rsp_turn_mode     (rsp_turn_mode),
      .csr_we            (csr_we),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata),
      .fail_count        (fail_count),
      .cmds_in_flight    (cmds_in_flight)
   );

   // 8 ns clock
   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // hard stop in case the handshake hangs; a correct run needs well under a tenth of this
   initial begin
      #2_000_000;
      $display("DONE: errors detected");
      $finish;
   end

   // offer one tick; called at a falling edge and returns at the falling edge after the
   // beat is taken, with valid still high so a back-to-back beat needs no second assignment
   task automatic send_tick(input int err, input logic turn_evt, input logic halt);
      int gap;
      // the first 30 of every 150 ticks go without gaps
      gap = ((ticks_sent % 150) < 30) ? 0 : $urandom_range(0, 5);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid         <= 1'b1;
      req_position_err  <= err[ERR_W-1:0];
      req_turn_finished <= turn_evt;
      req_halted        <= halt;
      do @(posedge clock); while (!req_ready);
      ticks_sent++;
      last_err_sent = err;
      @(negedge clock);
   endtask

   // tick with random content: mostly track-like errors, some extremes and full-range noise
   task automatic send_random_tick();
      int err;
      case ($urandom_range(0, 9))
         0: begin
            case ($urandom_range(0, 3))
               0: err = ERR_MIN;
               1: err = ERR_MAX;
               2: err = 0;
               default: err = -1;
            endcase
         end
         1, 2, 3: err = int'($urandom_range(0, 64)) - 32;
         4, 5, 6: begin
            // slow drift from the last error, as a real track would give
            err = last_err_sent + int'($urandom_range(0, 40)) - 20;
            if (err > ERR_MAX)
               err = ERR_MAX;
            if (err < ERR_MIN)
               err = ERR_MIN;
         end
         default: err = int'($signed($urandom_range(0, (1 << ERR_W) - 1) << (32 - ERR_W)))
                        >>> (32 - ERR_W);
      endcase
      send_tick(err, $urandom_range(0, 11) == 0, $urandom_range(0, 9) == 0);
   endtask

   // one register write beat; called at a falling edge, returns at the next one
   task automatic write_csr(input csr_index_type idx, input int value);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value[CSR_BITS-1:0];
      @(negedge clock);
   endtask

   // stop offering ticks and let the pipeline empty before touching the registers
   task automatic drain_pipeline();
      req_valid <= 1'b0;
      while (cmds_in_flight != 0) @(negedge clock);
      // four stage pipeline, plus a little margin
      repeat (8) @(negedge clock);
   endtask

   task automatic apply_setting(input setting_kind_type kind);
      int kp_n, kd_n, kp_t, kd_t, spd_n, spd_t, lim, hold;
      case (kind)
         SET_LOWEST: begin
            kp_n = 0; kd_n = 0; kp_t = 0; kd_t = 0;
            spd_n = 0; spd_t = 0; lim = 0; hold = 1;
         end
         SET_HIGHEST: begin
            kp_n = 4095; kd_n = 4095; kp_t = 4095; kd_t = 4095;
            spd_n = 99; spd_t = 99; lim = 99; hold = 255;
         end
         default: begin
            // shifting spreads gains over tiny to huge, so the clamp is not always hit
            kp_n  = $urandom_range(0, 4095) >> $urandom_range(0, 10);
            kd_n  = $urandom_range(0, 4095) >> $urandom_range(0, 10);
            kp_t  = $urandom_range(0, 4095) >> $urandom_range(0, 10);
            kd_t  = $urandom_range(0, 4095) >> $urandom_range(0, 10);
            // now and then a base speed or clamp above the two digit range
            spd_n = ($urandom_range(0, 5) == 0) ? $urandom_range(100, 127) : $urandom_range(0, 99);
            spd_t = ($urandom_range(0, 5) == 0) ? $urandom_range(100, 127) : $urandom_range(0, 99);
            lim   = ($urandom_range(0, 5) == 0) ? $urandom_range(100, 127) : $urandom_range(0, 99);
            // short holds so post-turn mode comes and goes often, or a zero hold for the wrapped setting
            hold  = (kind == SET_WRAPPED_HOLD) ? 0 : $urandom_range(1, 20);
         end
      endcase
      write_csr(CSR_NORMAL_KP, kp_n);
      write_csr(CSR_NORMAL_KD, kd_n);
      write_csr(CSR_TURN_KP, kp_t);
      write_csr(CSR_TURN_KD, kd_t);
      write_csr(CSR_NORMAL_SPEED, spd_n);
      write_csr(CSR_TURN_SPEED, spd_t);
      write_csr(CSR_MAX_CORR, lim);
      write_csr(CSR_HOLD_TICKS, hold);
      csr_we <= 1'b0;
   endtask

   task automatic run_phase(input setting_kind_type kind, input int n);
      drain_pipeline();
      apply_setting(kind);
      repeat (n) send_random_tick();
   endtask

   // result side: ready gaps drawn per beat, with quiet stretches and two long hold-offs
   initial begin
      int gap;
      rsp_ready  = 1'b1;
      cmds_taken = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_ready && rsp_valid) begin
            cmds_taken++;
            if (cmds_taken == 320 || cmds_taken == 700)
               gap = 90;   // long enough to back the pipeline up into the tick port
            else if ((cmds_taken % 170) < 35)
               gap = 0;
            else
               gap = $urandom_range(0, 5);
            @(negedge clock);
            if (gap != 0) begin
               rsp_ready <= 1'b0;
               repeat (gap) @(negedge clock);
               rsp_ready <= 1'b1;
            end
         end
      end
   end

   // main sequence
   initial begin
      reset             = 1'b1;
      req_valid         = 1'b0;
      req_position_err  = '0;
      req_turn_finished = 1'b0;
      req_halted        = 1'b0;
      csr_we            = 1'b0;
      csr_index         = CSR_NORMAL_KP;
      csr_wdata         = '0;
      ticks_sent        = 0;
      last_err_sent     = 0;

      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // default gains: error extremes, including the widest possible error step
      send_tick(0, 1'b0, 1'b0);
      send_tick(ERR_MAX, 1'b0, 1'b0);
      send_tick(ERR_MIN, 1'b0, 1'b0);
      // halted ticks still compute and still move the error history
      send_tick(-1, 1'b0, 1'b1);
      send_tick(1, 1'b0, 1'b1);

      // all gains at the top, clamp and normal speed above range, turn speed zero,
      // and a three tick hold to walk through the post-turn corners
      drain_pipeline();
      write_csr(CSR_NORMAL_KP, 4095);
      write_csr(CSR_NORMAL_KD, 4095);
      write_csr(CSR_TURN_KP, 4095);
      write_csr(CSR_TURN_KD, 4095);
      write_csr(CSR_NORMAL_SPEED, 127);
      write_csr(CSR_TURN_SPEED, 0);
      write_csr(CSR_MAX_CORR, 127);
      write_csr(CSR_HOLD_TICKS, 3);
      csr_we <= 1'b0;

      send_tick(5, 1'b1, 1'b0);          // turn event starts post-turn mode
      send_tick(-300, 1'b1, 1'b0);       // repeated event must not restart the count
      send_tick(700, 1'b1, 1'b0);        // event on the last hold tick is absorbed
      send_tick(ERR_MIN, 1'b0, 1'b0);    // back to normal, clamp acts as 99
      send_tick(ERR_MAX, 1'b0, 1'b0);
      send_tick(-1, 1'b1, 1'b1);         // turn event on a halted tick still counts
      send_tick(0, 1'b0, 1'b0);
      send_tick(0, 1'b0, 1'b0);          // hold runs out here
      send_tick(ERR_MAX, 1'b0, 1'b0);

      // random part across several settings, extremes first
      run_phase(SET_HIGHEST, 105);
      run_phase(SET_LOWEST, 105);
      run_phase(SET_RANDOM, 105);
      run_phase(SET_RANDOM, 105);
      // zero hold wraps the counter: post-turn mode lasts 256 ticks
      run_phase(SET_WRAPPED_HOLD, 300);
      run_phase(SET_RANDOM, 105);
      run_phase(SET_RANDOM, 105);
      run_phase(SET_RANDOM, 105);

      // wait out the last results, then a few cycles in case anything extra shows
      req_valid <= 1'b0;
      while (cmds_in_flight != 0) @(negedge clock);
      repeat (10) @(negedge clock);

      if (fail_count == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule
